@@ rtl/mpre_pkg.sv @@
// ----------------------------------------------------------------------------
// mpre_pkg: shared definitions for the MED predictive residual encoder
// Widths, register indexes, reset values and the scan position record.
// ----------------------------------------------------------------------------
package mpre_pkg;

  // Line buffer depth and derived widths.
  localparam int MAX_WIDTH  = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);

  // Fixed field widths.
  localparam int PIX_W      = 8;
  localparam int RES_W      = 9;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 16;
  localparam int SHIFT_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Effective width value must hold both the register and the buffer depth.
  localparam int WEFF_W = ($clog2(MAX_WIDTH + 1) > WIDTH_W) ?
                          $clog2(MAX_WIDTH + 1) : WIDTH_W;

  // Register reset values.
  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(480);
  localparam logic [SHIFT_W-1:0]  SHIFT_RST  = '0;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_QUANT_SHIFT  = 2'd2
  } cfg_reg_t;

  // Scan position of the item being accepted.
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             first;  // first row or first column: not predicted
    logic             last;   // last pixel of the frame
  } pos_t;

endpackage

@@ rtl/mpre_pix_if.sv @@
// ----------------------------------------------------------------------------
// mpre_pix_if: pixel input channel
// Valid/ready channel carrying one raw 8-bit sample per item.
// ----------------------------------------------------------------------------
interface mpre_pix_if;
  import mpre_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

@@ rtl/mpre_res_if.sv @@
// ----------------------------------------------------------------------------
// mpre_res_if: residual output channel
// Valid/ready channel carrying one signed residual and a frame end flag.
// ----------------------------------------------------------------------------
interface mpre_res_if;
  import mpre_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] residual;
  logic                    frame_end;

  modport source (output valid, output residual, output frame_end, input ready);
  modport sink   (input valid, input residual, input frame_end, output ready);
endinterface

@@ rtl/mpre_cfg_if.sv @@
// ----------------------------------------------------------------------------
// mpre_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface mpre_cfg_if;
  import mpre_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/mpre_ram.sv @@
// ----------------------------------------------------------------------------
// mpre_ram: generic single-clock RAM
// One write port and one read port with enable; read data is registered.
// ----------------------------------------------------------------------------
module mpre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while the enable is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/mpre_seq.sv @@
// ----------------------------------------------------------------------------
// mpre_seq: configuration registers and scan position counters
// Holds the frame geometry and shift, and tracks column and row of the next
// item; the counters advance on every accepted item.
// ----------------------------------------------------------------------------
module mpre_seq (
  input  logic                     clk,
  input  logic                     rst_n,
  mpre_cfg_if.sink                 cfg_wr,
  input  logic                     accept,
  output mpre_pkg::pos_t           pos,
  output logic [mpre_pkg::SHIFT_W-1:0] shift
);
  import mpre_pkg::*;

  logic [WIDTH_W-1:0]  frame_width_r;
  logic [HEIGHT_W-1:0] frame_height_r;
  logic [SHIFT_W-1:0]  quant_shift_r;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [HEIGHT_W-1:0] row_r, row_nxt;
  logic [WEFF_W-1:0]   width_eff;
  logic [HEIGHT_W-1:0] height_eff;
  logic [WEFF_W-1:0]   col_inc;
  logic [HEIGHT_W:0]   row_inc;
  logic                row_done;
  logic                frame_done;

  assign cfg_wr.ready = 1'b1;

  // Configuration writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RST;
      frame_height_r <= HEIGHT_RST;
      quant_shift_r  <= SHIFT_RST;
    end else if (cfg_wr.valid) begin
      case (cfg_reg_t'(cfg_wr.index))
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wr.data[WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wr.data[HEIGHT_W-1:0];
        REG_QUANT_SHIFT:  quant_shift_r  <= cfg_wr.data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the geometry to the supported range.
  always_comb begin
    if (frame_width_r < WIDTH_W'(2)) begin
      width_eff = WEFF_W'(2);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      width_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      width_eff = WEFF_W'(frame_width_r);
    end
    height_eff = (frame_height_r < HEIGHT_W'(2)) ? HEIGHT_W'(2) : frame_height_r;
  end

  // End of row and end of frame for the current position.
  assign col_inc    = WEFF_W'(col_r) + WEFF_W'(1);
  assign row_inc    = {1'b0, row_r} + (HEIGHT_W+1)'(1);
  assign row_done   = (col_inc >= width_eff);
  assign frame_done = row_done && (row_inc >= {1'b0, height_eff});

  // Next counter values.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (row_done) begin
        col_nxt = '0;
        row_nxt = frame_done ? '0 : row_inc[HEIGHT_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign pos.col   = col_r;
  assign pos.first = (col_r == '0) || (row_r == '0);
  assign pos.last  = frame_done;
  assign shift     = quant_shift_r;

endmodule

@@ rtl/mpre_core.sv @@
// ----------------------------------------------------------------------------
// mpre_core: prediction, residual and reconstruction stage
// Takes the item whose line buffer read has returned, forms the MED
// prediction, the quantized residual and the reconstructed value, writes the
// value back to the line buffer and places the result in the output register.
// ----------------------------------------------------------------------------
module mpre_core (
  input  logic                         clk,
  input  logic                         rst_n,
  mpre_pix_if.sink                     in_px,
  mpre_res_if.source                   out_res,
  input  mpre_pkg::pos_t               pos,
  input  logic [mpre_pkg::SHIFT_W-1:0] shift,
  input  logic [mpre_pkg::PIX_W-1:0]   above,
  output logic                         accept,
  output logic                         wb_en,
  output logic [mpre_pkg::COL_W-1:0]   wb_col,
  output logic [mpre_pkg::PIX_W-1:0]   wb_data
);
  import mpre_pkg::*;

  // Stage holding the item while its above neighbor is read.
  logic                    s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0]        s1_pixel_r;
  pos_t                    s1_pos_r;

  // Reconstructed neighbors.
  logic [PIX_W-1:0]        left_r;
  logic [PIX_W-1:0]        above_left_r;

  // Output register.
  logic                    out_valid_r, out_valid_nxt;
  logic signed [RES_W-1:0] out_res_r;
  logic                    out_end_r;

  logic                    advance;
  logic [PIX_W-1:0]        lo, hi, pred, pred_used;
  logic [PIX_W:0]          grad;
  logic signed [RES_W-1:0] diff, res_pred, res_raw, res;
  logic [PIX_W-1:0]        recon;

  // Handshake: the stage moves on whenever the output register is free or
  // drained in the same cycle.
  assign advance      = s1_valid_r && (!out_valid_r || out_res.ready);
  assign in_px.ready  = !s1_valid_r || advance;
  assign accept       = in_px.valid && in_px.ready;
  assign s1_valid_nxt = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? 1'b1 :
                         ((out_valid_r && out_res.ready) ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel_r <= in_px.pixel;
      s1_pos_r   <= pos;
    end
  end

  // Median edge detector.
  always_comb begin
    lo   = (left_r < above) ? left_r : above;
    hi   = (left_r < above) ? above : left_r;
    grad = {1'b0, left_r} + {1'b0, above} - {1'b0, above_left_r};
    if (above_left_r >= hi) begin
      pred = lo;
    end else if (above_left_r <= lo) begin
      pred = hi;
    end else begin
      pred = grad[PIX_W-1:0];
    end
  end

  // Residual with floor shift, and the reconstructed value.
  always_comb begin
    diff      = $signed({1'b0, s1_pixel_r}) - $signed({1'b0, pred});
    res_pred  = diff >>> shift;
    res_raw   = $signed({1'b0, s1_pixel_r >> shift});
    res       = s1_pos_r.first ? res_raw : res_pred;
    pred_used = s1_pos_r.first ? '0 : pred;
    recon     = pred_used + (res[PIX_W-1:0] << shift);
  end

  // Neighbor registers follow the scan as each item completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r       <= '0;
      above_left_r <= '0;
    end else if (advance) begin
      left_r       <= recon;
      above_left_r <= above;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
      out_end_r <= s1_pos_r.last;
    end
  end

  assign wb_en     = advance;
  assign wb_col    = s1_pos_r.col;
  assign wb_data   = recon;

  assign out_res.valid     = out_valid_r;
  assign out_res.residual  = out_res_r;
  assign out_res.frame_end = out_end_r;

endmodule

@@ rtl/med_predictive_residual_encoder.sv @@
// ----------------------------------------------------------------------------
// med_predictive_residual_encoder: MED predictive residual encoder
// An accepted pixel waits in the work stage while its line buffer read
// returns, then is predicted, written back and placed in the output register.
// Throughput: one pixel per cycle while the output side drains, bounded by
// one line buffer read and one write per item and the left-neighbor loop.
// Reset clears the counters, neighbors and valid flags and sets the
// configuration registers to their defaults; the line buffer is not cleared.
// ----------------------------------------------------------------------------
module med_predictive_residual_encoder (
  input  logic       clk,
  input  logic       rst_n,
  mpre_pix_if.sink   in_px,
  mpre_res_if.source out_res,
  mpre_cfg_if.sink   cfg_wr
);
  import mpre_pkg::*;

  pos_t               pos;
  logic [SHIFT_W-1:0] shift;
  logic               accept;
  logic [PIX_W-1:0]   above;
  logic               wb_en;
  logic [COL_W-1:0]   wb_col;
  logic [PIX_W-1:0]   wb_data;

  // Geometry registers and scan counters.
  mpre_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .accept (accept),
    .pos    (pos),
    .shift  (shift)
  );

  // Line buffer of the previous reconstructed row.
  mpre_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_buf (
    .clk   (clk),
    .we    (wb_en),
    .waddr (wb_col),
    .wdata (wb_data),
    .re    (accept),
    .raddr (pos.col),
    .rdata (above)
  );

  // Prediction and output stage.
  mpre_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_px   (in_px),
    .out_res (out_res),
    .pos     (pos),
    .shift   (shift),
    .above   (above),
    .accept  (accept),
    .wb_en   (wb_en),
    .wb_col  (wb_col),
    .wb_data (wb_data)
  );

  // Input stalls only when the work stage and the output register are full.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_px.ready |-> (out_res.valid && !out_res.ready))
    else $error("input stalled while the output side could drain");

  // The first column of a row is never predicted.
  a_first_col: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && pos.col == '0) |-> pos.first)
    else $error("first column item marked as predicted");

  // After the last pixel of a frame the scan restarts at the origin.
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && pos.last) |=> (pos.col == '0 && pos.first))
    else $error("scan did not restart after frame end");

endmodule
